// ===== hdl/ult_pkg.sv =====
package ult_pkg;

    localparam int ENTRIES_DEF     = 1024;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int IDX_W      = 10;
    localparam int LIMIT_W    = 16;
    localparam int INTERVAL_W = 16;
    localparam int TIME_W     = 32;
    localparam int SHOWN_W    = 16;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 24;

    typedef enum logic {
        OP_CHECK   = 1'b0,
        OP_RELEASE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC
    } t_state;

endpackage

// ===== hdl/usage_limit_table.sv =====
// Each beat is handled in ST_IDLE, which reads its table entry, then in ST_CALC, which updates it and writes it back.
// ST_CALC loads the result into the output register, and a waiting result that is not yet taken
// stalls that update; a new input beat is taken only in ST_IDLE, once the last beat is through.
// After reset the table is swept to zero, one entry a cycle, and no input beat is taken
// until every entry has been cleared.
module usage_limit_table #(
    parameter int ENTRIES     = ult_pkg::ENTRIES_DEF,
    parameter int COUNT_WIDTH = ult_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // entry_index, limit_max, interval_seconds, now_seconds, already_counted, zero pad
    input  logic [ult_pkg::S_TDATA_W-1:0] i_s_tdata,
    // opcode
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // admitted, usage_count, zero pad
    output logic [ult_pkg::M_TDATA_W-1:0] o_m_tdata
);

    import ult_pkg::*;

    localparam int     AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int     CW   = COUNT_WIDTH;
    localparam int     RW   = 2 * CW + TIME_W;
    localparam int     CMPW = 33;
    localparam int     RS   = IDX_W + AW;
    localparam longint RM   = ((longint'(1) << RS) + longint'(ENTRIES) - 1) / longint'(ENTRIES);

    t_state r_state, n_state;

    logic [AW-1:0]         r_clr_addr, n_clr_addr;
    logic [AW-1:0]         r_idx;
    t_opcode               r_op;
    logic [LIMIT_W-1:0]    r_limit;
    logic [INTERVAL_W-1:0] r_interval;
    logic [TIME_W-1:0]     r_now;
    logic                  r_counted;

    logic                  r_out_valid, n_out_valid;
    logic                  r_out_admit;
    logic [SHOWN_W-1:0]    r_out_count;

    logic [31:0]           idx_raw;
    logic [31:0]           idx_quo;
    logic [AW-1:0]         in_idx;
    logic                  s_accept;
    logic                  advance;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [RW-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [RW-1:0]         ram_rdata;

    logic [CW-1:0]         total_q, rate_q;
    logic [TIME_W-1:0]     ws_q;
    logic [CW-1:0]         total_n, rate_n;
    logic [TIME_W-1:0]     ws_n;
    logic [CW-1:0]         shown;
    logic [31:0]           shown32;
    logic                  admit;
    logic [CMPW-1:0]       limit_x;
    logic [CMPW-1:0]       want;
    logic                  expired;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == {CW{1'b1}}) ? v : v + CW'(1);
    endfunction

    // The index is reduced modulo ENTRIES by a reciprocal multiplication that is exact
    // over the whole index range.
    assign idx_raw  = 32'(i_s_tdata[IDX_W-1:0]);
    assign idx_quo  = (idx_raw * 32'(RM)) >> RS;
    assign in_idx   = AW'(idx_raw - idx_quo * 32'(ENTRIES));
    assign s_accept = i_s_tvalid && o_s_tready;
    assign advance  = (r_state == ST_CALC) && (!r_out_valid || i_m_tready);

    assign {total_q, rate_q, ws_q} = ram_rdata;

    always_comb begin
        limit_x = CMPW'(r_limit);
        want    = CMPW'(total_q) + CMPW'(!r_counted);
        expired = (CMPW'(ws_q) + CMPW'(r_interval)) <= CMPW'(r_now);
        total_n = total_q;
        rate_n  = rate_q;
        ws_n    = ws_q;
        admit   = 1'b1;
        shown   = total_q;
        if (r_op == OP_RELEASE) begin
            total_n = (total_q == '0) ? total_q : total_q - CW'(1);
            shown   = total_n;
        end else if (r_interval == '0) begin
            admit = (want <= limit_x);
            if (admit && !r_counted) begin
                total_n = sat_inc(total_q);
            end
            shown = total_n;
        end else begin
            if (expired) begin
                rate_n = CW'(1);
                ws_n   = r_now;
            end else begin
                rate_n = sat_inc(rate_q);
                admit  = (CMPW'(rate_n) <= limit_x);
            end
            if (admit && !r_counted) begin
                total_n = sat_inc(total_q);
            end
            shown = rate_n;
        end
        shown32 = 32'(shown);
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid;
        o_s_tready  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = {total_n, rate_n, ws_n};
        ram_raddr   = r_idx;
        if (o_m_tvalid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                ram_raddr  = in_idx;
                if (i_s_tvalid) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (advance) begin
                    ram_we      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_idx      <= in_idx;
            r_op       <= t_opcode'(i_s_tuser);
            r_limit    <= i_s_tdata[25:10];
            r_interval <= i_s_tdata[41:26];
            r_now      <= i_s_tdata[73:42];
            r_counted  <= i_s_tdata[74];
        end
        if (advance) begin
            r_out_admit <= admit;
            r_out_count <= shown32[SHOWN_W-1:0];
        end
    end

    ult_ram #(
        .WIDTH (RW),
        .DEPTH (ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W - SHOWN_W - 1){1'b0}}, r_out_count, r_out_admit};

endmodule

// ===== hdl/ult_ram.sv =====
module ult_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== hdl/ult_checker.sv =====
module ult_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [ult_pkg::S_TDATA_W-1:0] i_s_tdata,
    input logic                           i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [ult_pkg::M_TDATA_W-1:0] o_m_tdata
);

    import ult_pkg::*;

    // The table is being cleared straight after reset, so no beat may be taken.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input taken during the clearing sweep");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second beat taken while one is in progress");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !o_m_tvalid) |=> ##1 o_m_tvalid)
        else $error("result did not appear after an input beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed or dropped");

endmodule

bind usage_limit_table ult_checker u_ult_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ult_pkg::*;

    localparam int TABLE_SIZE  = 1024;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct {
        t_opcode     op;
        logic [9:0]  idx;
        logic [15:0] limit_max;
        logic [15:0] interval;
        logic [31:0] now;
        logic        counted;
    } t_request;

    typedef struct {
        logic        admitted;
        logic [15:0] usage;
    } t_verdict;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    // entry_index, limit_max, interval_seconds, now_seconds, already_counted, zero pad
    logic [S_TDATA_W-1:0] i_s_tdata;
    // opcode
    logic                 i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    // admitted, usage_count, zero pad
    logic [M_TDATA_W-1:0] o_m_tdata;

    logic [15:0] held_total   [TABLE_SIZE];
    logic [15:0] window_count [TABLE_SIZE];
    logic [31:0] window_opened[TABLE_SIZE];

    t_verdict pending_verdicts[$];
    int       requests_sent    = 0;
    int       results_checked  = 0;
    int       admitted_seen    = 0;
    int       rejected_seen    = 0;
    int       error_count      = 0;
    int       cycle_count      = 0;
    int       sink_hold_cycles = 0;
    bit       src_pacing       = 1'b1;
    bit       sink_pacing      = 1'b1;
    logic [31:0] clock_seconds = 32'd1000;

    usage_limit_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [15:0] bump(logic [15:0] value);
        return (value == 16'hFFFF) ? value : value + 16'd1;
    endfunction

    function automatic t_verdict judge_request(t_request req);
        t_verdict verdict;
        logic [16:0] wanted;
        logic [32:0] window_end;
        verdict.admitted = 1'b1;
        if (req.op == OP_RELEASE) begin
            if (held_total[req.idx] != 16'd0) begin
                held_total[req.idx] = held_total[req.idx] - 16'd1;
            end
            verdict.usage = held_total[req.idx];
        end else if (req.interval == 16'd0) begin
            wanted = {1'b0, held_total[req.idx]} + (req.counted ? 17'd0 : 17'd1);
            if (wanted > {1'b0, req.limit_max}) begin
                verdict.admitted = 1'b0;
            end else if (!req.counted) begin
                held_total[req.idx] = bump(held_total[req.idx]);
            end
            verdict.usage = held_total[req.idx];
        end else begin
            window_end = {1'b0, window_opened[req.idx]} + {17'd0, req.interval};
            if (window_end <= {1'b0, req.now}) begin
                window_count[req.idx]  = 16'd1;
                window_opened[req.idx] = req.now;
            end else begin
                window_count[req.idx] = bump(window_count[req.idx]);
                if (window_count[req.idx] > req.limit_max) begin
                    verdict.admitted = 1'b0;
                end
            end
            if (verdict.admitted && !req.counted) begin
                held_total[req.idx] = bump(held_total[req.idx]);
            end
            verdict.usage = window_count[req.idx];
        end
        return verdict;
    endfunction

    task automatic send_request(t_request req);
        int gap;
        gap = src_pacing ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req.op;
        i_s_tdata  <= {5'd0, req.counted, req.now, req.interval, req.limit_max, req.idx};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        pending_verdicts.push_back(judge_request(req));
        requests_sent++;
    endtask

    task automatic send_fields(t_opcode op, int idx, int lim, int ivl, logic [31:0] now,
                               bit counted);
        t_request req;
        req.op        = op;
        req.idx       = idx[9:0];
        req.limit_max = lim[15:0];
        req.interval  = ivl[15:0];
        req.now       = now;
        req.counted   = counted;
        send_request(req);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_concurrent_limits();
        send_fields(OP_CHECK, 5, 0, 0, 32'd0, 1'b0);
        send_fields(OP_CHECK, 5, 2, 0, 32'd0, 1'b0);
        send_fields(OP_CHECK, 5, 2, 0, 32'd0, 1'b0);
        send_fields(OP_CHECK, 5, 2, 0, 32'd0, 1'b0);
        send_fields(OP_CHECK, 5, 2, 0, 32'd0, 1'b1);
        send_fields(OP_CHECK, 5, 1, 0, 32'd0, 1'b1);
        send_fields(OP_RELEASE, 5, 65535, 65535, 32'hFFFF_FFFF, 1'b1);
        send_fields(OP_RELEASE, 5, 0, 0, 32'd0, 1'b0);
        send_fields(OP_RELEASE, 5, 0, 0, 32'd0, 1'b0);
        send_fields(OP_CHECK, 1023, 65535, 0, 32'd0, 1'b0);
        send_fields(OP_CHECK, 0, 0, 0, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_rate_windows();
        send_fields(OP_CHECK, 7, 0, 10, 32'd100, 1'b0);
        send_fields(OP_CHECK, 7, 0, 10, 32'd105, 1'b0);
        send_fields(OP_CHECK, 7, 2, 10, 32'd106, 1'b1);
        send_fields(OP_CHECK, 7, 3, 10, 32'd109, 1'b0);
        send_fields(OP_CHECK, 7, 3, 10, 32'd110, 1'b0);
        send_fields(OP_RELEASE, 7, 0, 10, 32'd111, 1'b0);
        send_fields(OP_CHECK, 1000, 1, 32, 32'hFFFF_FFF0, 1'b0);
        send_fields(OP_CHECK, 1000, 1, 65535, 32'hFFFF_FFFF, 1'b0);
        send_fields(OP_CHECK, 1000, 1, 65535, 32'hFFFF_FFFF, 1'b0);
        send_fields(OP_CHECK, 1000, 65535, 1, 32'hFFFF_FFFF, 1'b0);
        send_fields(OP_CHECK, 1001, 65535, 65535, 32'hFFFF_FFFF, 1'b1);
        drain_results();
    endtask

    // Window open throughout the windowed checks, so both counters of the entry keep climbing on every such beat.
    task automatic test_steady_climb();
        src_pacing  = 1'b0;
        sink_pacing = 1'b0;
        for (int n = 0; n < 64; n++) begin
            send_fields(OP_CHECK, 300, 65535, 1, 32'd0, 1'b0);
        end
        send_fields(OP_CHECK, 300, 65535, 0, 32'd0, 1'b0);
        send_fields(OP_RELEASE, 300, 0, 0, 32'd0, 1'b0);
        drain_results();
        src_pacing  = 1'b1;
        sink_pacing = 1'b1;
    endtask

    task automatic test_back_pressure();
        src_pacing       = 1'b0;
        sink_hold_cycles = 200;
        for (int n = 0; n < 30; n++) begin
            send_fields(OP_CHECK, n % 4 + 40, 20, n % 2, clock_seconds, 1'b0);
        end
        src_pacing = 1'b1;
        drain_results();
    endtask

    task automatic test_random_traffic(int count);
        t_request req;
        int       pool_base;
        pool_base = 64;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                src_pacing  = ($urandom_range(0, 3) != 0);
                sink_pacing = ($urandom_range(0, 3) != 0);
                pool_base   = $urandom_range(0, TABLE_SIZE - 8);
            end
            if ($urandom_range(0, 99) < 10) begin
                req.op        = t_opcode'($urandom_range(0, 1));
                req.idx       = 10'($urandom_range(0, TABLE_SIZE - 1));
                req.limit_max = 16'($urandom_range(0, 65535));
                req.interval  = 16'($urandom_range(0, 65535));
                req.now       = $urandom();
                req.counted   = 1'($urandom_range(0, 1));
            end else begin
                clock_seconds = clock_seconds + $urandom_range(0, 5);
                req.op        = ($urandom_range(0, 3) == 0) ? OP_RELEASE : OP_CHECK;
                req.idx       = 10'(pool_base + $urandom_range(0, 7));
                req.limit_max = 16'($urandom_range(0, 6));
                req.interval  = ($urandom_range(0, 1) == 0) ? 16'd0
                                                             : 16'($urandom_range(1, 20));
                req.now       = clock_seconds;
                req.counted   = ($urandom_range(0, 9) < 3);
            end
            send_request(req);
        end
        drain_results();
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result beat: tdata %h", o_m_tdata);
                error_count++;
            end else begin
                want = pending_verdicts.pop_front();
                results_checked++;
                if (o_m_tdata[0]) admitted_seen++;
                else rejected_seen++;
                if (o_m_tdata[0] !== want.admitted) begin
                    $error("admitted: expected %0d, got %0d", want.admitted, o_m_tdata[0]);
                    error_count++;
                end
                if (o_m_tdata[16:1] !== want.usage) begin
                    $error("usage_count: expected %0d, got %0d", want.usage, o_m_tdata[16:1]);
                    error_count++;
                end
            end
        end
    end

    initial begin : result_sink
        int stall;
        forever begin
            stall = sink_pacing ? $urandom_range(0, 6) : 0;
            if (sink_hold_cycles > 0) begin
                stall            = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        for (int n = 0; n < TABLE_SIZE; n++) begin
            held_total[n]    = 16'd0;
            window_count[n]  = 16'd0;
            window_opened[n] = 32'd0;
        end
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= OP_CHECK;
        i_s_tdata  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_concurrent_limits();
        test_rate_windows();
        test_steady_climb();
        test_back_pressure();
        test_random_traffic(1000);

        drain_results();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests and checked %0d results (%0d admitted, %0d rejected),",
                 requests_sent, results_checked, admitted_seen, rejected_seen);
        $display("covering concurrent and windowed limits, releases, long runs and stalls.");
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
